// ----- hw/rtl/rma_pkg.sv -----
// ----------------------------------------------------------------------------
// rma_pkg
// Shared opcodes and the decoded-instruction type for the register machine.
// ----------------------------------------------------------------------------
package rma_pkg;

    localparam int DataW = 32;
    localparam int IdxW  = 5;

    typedef enum logic [3:0] {
        OP_IN   = 4'd0,
        OP_OUT  = 4'd1,
        OP_MOV  = 4'd2,
        OP_XCHG = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_MUL  = 4'd6,
        OP_DIV  = 4'd7,
        OP_MOD  = 4'd8,
        OP_AND  = 4'd9,
        OP_OR   = 4'd10,
        OP_XOR  = 4'd11
    } op_t;

    // decoded instruction handed from front to back
    typedef struct packed {
        logic [3:0]      op;
        logic [IdxW-1:0] dst;
        logic [IdxW-1:0] xa;    // first operand register
        logic [IdxW-1:0] xb;    // second operand register
        logic [IdxW-1:0] sa;    // raw source a, for mov/xchg
        logic [DataW-1:0] imm;
    } instr_t;

endpackage

// ----- hw/rtl/register_machine_alu.sv -----
// ----------------------------------------------------------------------------
// register_machine_alu
// Decoded-instruction interpreter over a file of signed 32-bit registers.
// ----------------------------------------------------------------------------
// Usage: instruction beats enter on the s_ channel (valid/ready); OUT and a
// divide by zero produce one result beat on the m_ channel, every other
// instruction produces none. The front accepts and classifies beats into a
// two-entry queue; the back executes one instruction at a time.
// IN, MOV, XCHG and the logic/add ops finish as the back takes them; OUT
// and a divide by zero hold the back until the result beat is taken; MUL
// writes a registered product from ST_MUL; DIV and MOD wait in ST_DIV on
// the bit-serial divider (one quotient bit per cycle). A registered result
// beat appears in the cycle after its instruction leaves the queue.
// The back holds the next instruction while a result waits on a stalled
// m_ready; the front keeps taking beats until its queue is full.
// Reset (aresetn low, synchronous) clears all registers to zero and empties
// the queue.
// ----------------------------------------------------------------------------
module register_machine_alu #(
    parameter int NUM_REGS = 26
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [3:0]   s_req_type,
    input  logic [4:0]   s_dst_reg,
    input  logic [4:0]   s_src_a_reg,
    input  logic [4:0]   s_src_b_reg,
    input  logic         s_three_operand,
    input  logic [31:0]  s_imm_value,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [31:0]  m_out_value,
    output logic         m_div_by_zero
);
    import rma_pkg::*;

    logic   q_valid, q_ready;
    instr_t q_data;

    rma_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_dst_reg,
        .s_src_a_reg, .s_src_b_reg, .s_three_operand, .s_imm_value,
        .q_valid, .q_ready, .q_data
    );

    rma_back #(.NUM_REGS(NUM_REGS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_out_value, .m_div_by_zero
    );

endmodule

// ----- hw/rtl/rma_front.sv -----
// ----------------------------------------------------------------------------
// rma_front
// Accepts instruction beats, drops unused opcodes, resolves operand
// registers and pushes into a two-entry queue toward the execute side.
// ----------------------------------------------------------------------------
module rma_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_req_type,
    input  logic [4:0]           s_dst_reg,
    input  logic [4:0]           s_src_a_reg,
    input  logic [4:0]           s_src_b_reg,
    input  logic                 s_three_operand,
    input  logic [31:0]          s_imm_value,
    output logic                 q_valid,
    input  logic                 q_ready,
    output rma_pkg::instr_t      q_data
);
    import rma_pkg::*;

    instr_t      mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    instr_t      dec;
    logic        push, pop;

    // classify the incoming beat
    always_comb begin
        dec.op  = s_req_type;
        dec.dst = s_dst_reg;
        dec.sa  = s_src_a_reg;
        dec.imm = s_imm_value;
        if (s_three_operand) begin
            dec.xa = s_src_a_reg;
            dec.xb = s_src_b_reg;
        end else begin
            dec.xa = s_dst_reg;
            dec.xb = s_src_a_reg;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && (s_req_type <= OP_XOR);
    assign pop     = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rptr_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= dec;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not follow push");

endmodule

// ----- hw/rtl/rma_divider.sv -----
// ----------------------------------------------------------------------------
// rma_divider
// Restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rma_divider (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [31:0]  dividend,
    input  logic [31:0]  divisor,
    output logic         done,
    output logic [31:0]  quotient,
    output logic [31:0]  remainder
);
    logic [31:0] q_reg, d_reg;
    logic [32:0] r_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg, nq_reg, nr_reg;
    logic [32:0] shifted, diff;

    assign shifted   = {r_reg[31:0], q_reg[31]};
    assign diff      = shifted - {1'b0, d_reg};
    assign done      = done_reg;
    assign quotient  = nq_reg ? (32'd0 - q_reg) : q_reg;
    assign remainder = nr_reg ? (32'd0 - r_reg[31:0]) : r_reg[31:0];

    // one bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                q_reg    <= dividend[31] ? (32'd0 - dividend) : dividend;
                d_reg    <= divisor[31] ? (32'd0 - divisor) : divisor;
                r_reg    <= 33'd0;
                nq_reg   <= dividend[31] ^ divisor[31];
                nr_reg   <= dividend[31];
            end else if (busy_reg) begin
                if (!diff[32]) begin
                    r_reg <= diff;
                    q_reg <= {q_reg[30:0], 1'b1};
                end else begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/rma_back.sv -----
// ----------------------------------------------------------------------------
// rma_back
// Executes decoded instructions on the register file and drives results.
// ----------------------------------------------------------------------------
module rma_back #(
    parameter int NUM_REGS = 26
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  rma_pkg::instr_t      q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_out_value,
    output logic                 m_div_by_zero
);
    import rma_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

    state_t      state_reg;
    logic [31:0] rf_reg [NUM_REGS];
    logic [31:0] x, y, vd, va, alu;
    logic [31:0] prod_reg;
    logic [4:0]  dst_reg;
    logic        mod_reg, div_start;
    logic        div_done;
    logic [31:0] div_q, div_r;
    logic        take;

    function automatic logic [31:0] rd(input logic [31:0] f [NUM_REGS],
                                       input logic [4:0] i);
        logic [31:0] v;
        v = 32'd0;
        if (32'(i) < NUM_REGS) v = f[i];
        return v;
    endfunction

    assign x  = rd(rf_reg, q_data.xa);
    assign y  = rd(rf_reg, q_data.xb);
    assign vd = rd(rf_reg, q_data.dst);
    assign va = rd(rf_reg, q_data.sa);

    // combinational alu
    always_comb begin
        case (q_data.op)
            OP_ADD:  alu = x + y;
            OP_SUB:  alu = x - y;
            OP_AND:  alu = x & y;
            OP_OR:   alu = x | y;
            OP_XOR:  alu = x ^ y;
            default: alu = 32'd0;
        endcase
    end

    assign take      = q_valid && q_ready;
    assign q_ready   = (state_reg == ST_IDLE) && !m_valid;
    assign div_start = take && (q_data.op == OP_DIV || q_data.op == OP_MOD)
                       && (y != 32'd0);

    rma_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (x),
        .divisor   (y),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // execute sequencer, register file and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) rf_reg[i] <= 32'd0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        dst_reg <= q_data.dst;
                        mod_reg <= (q_data.op == OP_MOD);
                        case (q_data.op)
                            OP_IN: if (32'(q_data.dst) < NUM_REGS)
                                rf_reg[q_data.dst] <= q_data.imm;
                            OP_OUT: begin
                                m_valid       <= 1'b1;
                                m_out_value   <= vd;
                                m_div_by_zero <= 1'b0;
                            end
                            OP_MOV: if (32'(q_data.dst) < NUM_REGS)
                                rf_reg[q_data.dst] <= va;
                            OP_XCHG: begin
                                if (32'(q_data.sa) < NUM_REGS)
                                    rf_reg[q_data.sa] <= vd;
                                if (32'(q_data.dst) < NUM_REGS)
                                    rf_reg[q_data.dst] <= va;
                            end
                            OP_MUL: begin
                                prod_reg  <= x * y;
                                state_reg <= ST_MUL;
                            end
                            OP_DIV, OP_MOD: begin
                                if (y == 32'd0) begin
                                    m_valid       <= 1'b1;
                                    m_out_value   <= 32'd0;
                                    m_div_by_zero <= 1'b1;
                                end else begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            default: if (32'(q_data.dst) < NUM_REGS)
                                rf_reg[q_data.dst] <= alu;
                        endcase
                    end
                end
                ST_MUL: begin
                    if (32'(dst_reg) < NUM_REGS) rf_reg[dst_reg] <= prod_reg;
                    state_reg <= ST_IDLE;
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (32'(dst_reg) < NUM_REGS)
                            rf_reg[dst_reg] <= mod_reg ? div_r : div_q;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_div_by_zero) |-> (m_out_value == 32'd0))
        else $error("error result carries a value");

endmodule

// ----- tb/tb_register_machine_alu.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_machine_alu
// Self-checking bench for the register machine interpreter: directed table of
// instructions followed by random programs, every result beat compared with a
// software copy of the register file under three idle patterns.
// ----------------------------------------------------------------------------
module tb_register_machine_alu;
    import rma_pkg::*;

    localparam int NREGS  = 26;
    localparam int NRAND  = 750;
    localparam int DRAIN  = 80;

    typedef struct {
        logic [3:0]  op;
        logic [4:0]  dst;
        logic [4:0]  sa;
        logic [4:0]  sb;
        logic        three;
        logic [31:0] imm;
        bit          has_exp;   // expected beat typed in the table
        logic [31:0] exp_val;
        logic        exp_dz;
    } instr_row_t;

    typedef struct {
        logic [31:0] val;
        logic        dz;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_req_type;
    logic [4:0]  s_dst_reg;
    logic [4:0]  s_src_a_reg;
    logic [4:0]  s_src_b_reg;
    logic        s_three_operand;
    logic [31:0] s_imm_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_value;
    logic        m_div_by_zero;

    logic [31:0] regs_model [NREGS];
    result_t     result_q [$];
    int          n_err;
    int          n_beats;
    int          n_instr;
    int          s_idle_pct;
    int          m_idle_pct;
    bit          done;

    register_machine_alu #(.NUM_REGS(NREGS)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_dst_reg       (s_dst_reg),
        .s_src_a_reg     (s_src_a_reg),
        .s_src_b_reg     (s_src_b_reg),
        .s_three_operand (s_three_operand),
        .s_imm_value     (s_imm_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_value     (m_out_value),
        .m_div_by_zero   (m_div_by_zero)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20ms;
        $display("[register_machine_alu] ERROR");
        $finish;
    end

    function automatic logic [31:0] reg_read(logic [4:0] idx);
        return (idx < NREGS) ? regs_model[idx] : 32'd0;
    endfunction

    function automatic void reg_write(logic [4:0] idx, logic [31:0] v);
        if (idx < NREGS) regs_model[idx] = v;
    endfunction

    // truncating signed divide on bit patterns, divisor nonzero
    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit rem);
        logic [31:0] ua, ub, q, r;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        r  = ua % ub;
        if (rem) return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // execute one instruction on the model, queue any result beat
    task automatic execute_instr(instr_row_t it);
        logic [31:0] x, y, t, res;
        result_t     r;
        case (it.op)
            OP_IN:  reg_write(it.dst, it.imm);
            OP_OUT: begin
                r.val = reg_read(it.dst);
                r.dz  = 1'b0;
                result_q.push_back(r);
            end
            OP_MOV: reg_write(it.dst, reg_read(it.sa));
            OP_XCHG: begin
                t = reg_read(it.dst);
                reg_write(it.dst, reg_read(it.sa));
                reg_write(it.sa, t);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR: begin
                if (it.three) begin
                    x = reg_read(it.sa);
                    y = reg_read(it.sb);
                end else begin
                    x = reg_read(it.dst);
                    y = reg_read(it.sa);
                end
                if ((it.op == OP_DIV || it.op == OP_MOD) && y == 32'd0) begin
                    r.val = 32'd0;
                    r.dz  = 1'b1;
                    result_q.push_back(r);
                end else begin
                    case (it.op)
                        OP_ADD:  res = x + y;
                        OP_SUB:  res = x - y;
                        OP_MUL:  res = x * y;
                        OP_DIV:  res = sdiv(x, y, 1'b0);
                        OP_MOD:  res = sdiv(x, y, 1'b1);
                        OP_AND:  res = x & y;
                        OP_OR:   res = x | y;
                        default: res = x ^ y;
                    endcase
                    reg_write(it.dst, res);
                end
            end
            default: ;
        endcase
    endtask

    // send one beat, honoring the sender idle rate
    task automatic send_instr(instr_row_t it);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= it.op;
        s_dst_reg       <= it.dst;
        s_src_a_reg     <= it.sa;
        s_src_b_reg     <= it.sb;
        s_three_operand <= it.three;
        s_imm_value     <= it.imm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.has_exp) begin
            if (result_q.size() == 0 || result_q[$].val !== it.exp_val ||
                    result_q[$].dz !== it.exp_dz) begin
                n_err++;
                if (n_err <= 10)
                    $display("table row disagrees with model: op %0d exp %h/%b",
                             it.op, it.exp_val, it.exp_dz);
            end
        end
        n_instr++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(9) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_row_t rand_instr();
        instr_row_t it;
        int k;
        k = $urandom_range(99);
        if (k < 3)       it.op = 4'(12 + $urandom_range(3));
        else if (k < 25) it.op = OP_IN;
        else if (k < 40) it.op = OP_OUT;
        else             it.op = 4'($urandom_range(2, 11));
        // mostly in range, now and then an index past the file
        it.dst   = ($urandom_range(15) == 0) ? 5'($urandom_range(26, 31))
                                             : 5'($urandom_range(NREGS - 1));
        it.sa    = ($urandom_range(15) == 0) ? 5'($urandom_range(26, 31))
                                             : 5'($urandom_range(NREGS - 1));
        it.sb    = ($urandom_range(15) == 0) ? 5'($urandom_range(26, 31))
                                             : 5'($urandom_range(NREGS - 1));
        it.three = $urandom_range(1);
        it.imm   = rand_operand();
        it.has_exp = 1'b0;
        it.exp_val = '0;
        it.exp_dz  = 1'b0;
        return it;
    endfunction

    function automatic instr_row_t mk(logic [3:0] op, logic [4:0] d, logic [4:0] a,
                                      logic [4:0] b, logic th, logic [31:0] imm,
                                      bit he = 0, logic [31:0] ev = 0, logic ez = 0);
        instr_row_t it;
        it.op = op; it.dst = d; it.sa = a; it.sb = b; it.three = th; it.imm = imm;
        it.has_exp = he; it.exp_val = ev; it.exp_dz = ez;
        return it;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_beats++;
            if (result_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat %h/%b",
                                          m_out_value, m_div_by_zero);
            end else begin
                if (m_out_value !== result_q[0].val ||
                        m_div_by_zero !== result_q[0].dz) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp %h/%b got %h/%b", result_q[0].val,
                                 result_q[0].dz, m_out_value, m_div_by_zero);
                end
                void'(result_q.pop_front());
            end
        end
    end

    // receiver stall
    always @(negedge aclk) begin
        if (!done) m_ready <= ($urandom_range(99) >= m_idle_pct);
        else       m_ready <= 1'b1;
    end

    initial begin
        instr_row_t table_rows [$];
        instr_row_t it;
        int wait_cnt;
        aresetn = 1'b0; s_valid = 1'b0;
        s_req_type = '0; s_dst_reg = '0; s_src_a_reg = '0; s_src_b_reg = '0;
        s_three_operand = 1'b0; s_imm_value = '0;
        n_err = 0; n_beats = 0; n_instr = 0; done = 0;
        s_idle_pct = 18; m_idle_pct = 46;
        foreach (regs_model[i]) regs_model[i] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        table_rows.push_back(mk(OP_OUT, 25, 0, 0, 0, 0, 1, 32'd0, 0));
        table_rows.push_back(mk(OP_IN, 0, 0, 0, 0, 32'h8000_0000));
        table_rows.push_back(mk(OP_OUT, 0, 0, 0, 0, 0, 1, 32'h8000_0000, 0));
        table_rows.push_back(mk(OP_IN, 1, 0, 0, 0, 32'hFFFF_FFFF));
        table_rows.push_back(mk(OP_IN, 25, 0, 0, 0, 32'h7FFF_FFFF));
        table_rows.push_back(mk(OP_DIV, 2, 0, 1, 1, 0));
        table_rows.push_back(mk(OP_OUT, 2, 0, 0, 0, 0, 1, 32'h8000_0000, 0));
        table_rows.push_back(mk(OP_MOD, 3, 0, 1, 1, 0));
        table_rows.push_back(mk(OP_OUT, 3, 0, 0, 0, 0, 1, 32'd0, 0));
        table_rows.push_back(mk(OP_DIV, 0, 4, 0, 0, 0, 1, 32'd0, 1));
        table_rows.push_back(mk(OP_MOD, 5, 25, 6, 1, 0, 1, 32'd0, 1));
        table_rows.push_back(mk(OP_ADD, 4, 25, 1, 1, 0));
        table_rows.push_back(mk(OP_SUB, 5, 0, 25, 1, 0));
        table_rows.push_back(mk(OP_MUL, 25, 25, 0, 0, 0));
        table_rows.push_back(mk(OP_AND, 6, 0, 1, 1, 0));
        table_rows.push_back(mk(OP_OR, 7, 25, 1, 1, 0));
        table_rows.push_back(mk(OP_XOR, 7, 1, 0, 0, 0));
        table_rows.push_back(mk(OP_MOV, 8, 25, 0, 0, 0));
        table_rows.push_back(mk(OP_XCHG, 8, 0, 0, 0, 0));
        table_rows.push_back(mk(OP_XCHG, 8, 8, 0, 0, 0));
        table_rows.push_back(mk(OP_IN, 31, 0, 0, 0, 32'h1234_5678));
        table_rows.push_back(mk(OP_OUT, 31, 0, 0, 0, 0, 1, 32'd0, 0));
        table_rows.push_back(mk(4'd15, 31, 31, 31, 1, 32'hFFFF_FFFF));
        table_rows.push_back(mk(OP_MOV, 9, 30, 0, 0, 0));
        table_rows.push_back(mk(OP_OUT, 9, 0, 0, 0, 0, 1, 32'd0, 0));
        foreach (table_rows[i]) begin
            execute_instr(table_rows[i]);
            send_instr(table_rows[i]);
        end

        // random programs in three idle phases
        for (int ph = 0; ph < 3; ph++) begin
            s_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 46 : 0;
            m_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 18 : 0;
            for (int n = 0; n < NRAND / 3; n++) begin
                it = rand_instr();
                execute_instr(it);
                send_instr(it);
            end
        end

        // drain
        s_valid <= 1'b0;
        done = 1;
        wait_cnt = 0;
        while (result_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (DRAIN) @(posedge aclk);
        if (result_q.size() != 0) n_err++;
        $display("ran %0d instructions, checked %0d result beats, %0d errors",
                 n_instr, n_beats, n_err);
        if (n_err == 0) $display("[register_machine_alu] OK");
        else            $display("[register_machine_alu] ERROR");
        $finish;
    end

endmodule
